[hdl/lerw_pkg.sv]
// ----------------------------------------------------------------------------
// lerw_pkg
// shared types for the log entry reorder window: command codes and the
// request and result transaction layouts
// ----------------------------------------------------------------------------
package lerw_pkg;

    typedef enum logic [1:0] {
        CMD_SET_HEAD = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_GET_NEXT = 2'd2,
        CMD_CONTAINS = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] index;
        logic [31:0] term;
        logic [63:0] new_payload;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [31:0] entry_prev_index;
        logic [31:0] entry_prev_term;
        logic [63:0] entry_payload;
    } t_out_item;

endpackage

[hdl/lerw_ram.sv]
// ----------------------------------------------------------------------------
// lerw_ram
// simple dual-port synchronous ram, one write port, one read port with
// registered read data
// ----------------------------------------------------------------------------
module lerw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/log_entry_reorder_window_top.sv]
// ----------------------------------------------------------------------------
// log_entry_reorder_window_top
// sliding window reorder buffer of log entries held in one slot ram
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// result appears on o_result for one cycle with o_valid, and the receiver
// cannot hold it off. Add and contains answer in the next cycle and leave
// the block ready at once. Get next reads the slot ram, then does the
// compare and the write back. Set head clears every slot the window slides
// over, or sweeps the whole slot ram one entry a cycle when the term
// changes or the new head lies outside the window. After reset busy stays
// high during a clearing pass over the slot ram.
module log_entry_reorder_window_top
    import lerw_pkg::*;
#(
    parameter int DEPTH         = 1024,
    parameter int PAYLOAD_WIDTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 1 + 32 + 32 + PAYLOAD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_SLIDE = 4'b0100,
        S_CLEAR = 4'b1000
    } t_state;

    t_state            r_state,   n_state;
    logic [31:0]       r_term,    n_term;
    logic [31:0]       r_base,    n_base;
    logic [31:0]       r_target,  n_target;
    logic [31:0]       r_req_idx, n_req_idx;
    logic [31:0]       r_req_trm, n_req_trm;
    logic [ADDR_W-1:0] r_ptr,     n_ptr;
    logic              r_report,  n_report;
    logic              r_out_vld, n_out_vld;
    t_out_item         r_out,     n_out;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              accept;
    logic [32:0]       win_end;
    logic              in_win;
    logic [31:0]       add_pos;
    logic [31:0]       base_inc;
    logic              rd_valid;
    logic [31:0]       rd_idx;
    logic [31:0]       rd_term;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;

    lerw_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept     = start && (r_state == S_IDLE);
    assign win_end    = {1'b0, r_base} + 33'(DEPTH);
    assign in_win     = (i_item.index >= r_base) && ({1'b0, i_item.index} < win_end);
    assign add_pos    = i_item.index + 32'd1;
    assign base_inc   = r_base + 32'd1;
    assign ram_raddr  = r_base[ADDR_W-1:0];
    assign rd_valid   = ram_rdata[WORD_W-1];
    assign rd_idx     = ram_rdata[WORD_W-2 -: 32];
    assign rd_term    = ram_rdata[WORD_W-34 -: 32];
    assign rd_payload = ram_rdata[PAYLOAD_WIDTH-1:0];

    always_comb begin
        n_state   = r_state;
        n_term    = r_term;
        n_base    = r_base;
        n_target  = r_target;
        n_req_idx = r_req_idx;
        n_req_trm = r_req_trm;
        n_ptr     = r_ptr;
        n_report  = r_report;
        n_out_vld = 1'b0;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_waddr = r_base[ADDR_W-1:0];
        ram_wdata = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.cmd)
                        CMD_SET_HEAD: begin
                            n_term = i_item.term;
                            if ((i_item.term != r_term) || !in_win) begin
                                n_base   = i_item.index;
                                n_ptr    = '0;
                                n_report = 1'b1;
                                n_state  = S_CLEAR;
                            end else if (r_base == i_item.index) begin
                                n_out_vld = 1'b1;
                                n_out     = '0;
                            end else begin
                                n_target = i_item.index;
                                n_state  = S_SLIDE;
                            end
                        end
                        CMD_ADD: begin
                            ram_we    = 1'b1;
                            ram_waddr = add_pos[ADDR_W-1:0];
                            ram_wdata = {1'b1, i_item.index, i_item.term,
                                         i_item.new_payload[PAYLOAD_WIDTH-1:0]};
                            n_out_vld = 1'b1;
                            n_out     = '0;
                        end
                        CMD_GET_NEXT: begin
                            n_req_idx = i_item.index;
                            n_req_trm = i_item.term;
                            n_state   = S_CHECK;
                        end
                        default: begin
                            n_out_vld   = 1'b1;
                            n_out       = '0;
                            n_out.found = in_win;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                n_out_vld = 1'b1;
                n_out     = '0;
                n_state   = S_IDLE;
                if (rd_valid && (rd_idx == r_req_idx) && (rd_term == r_req_trm)) begin
                    ram_we                 = 1'b1;
                    n_base                 = base_inc;
                    n_out.found            = 1'b1;
                    n_out.entry_prev_index = rd_idx;
                    n_out.entry_prev_term  = rd_term;
                    n_out.entry_payload    = 64'(rd_payload);
                end
            end
            S_SLIDE: begin
                ram_we = 1'b1;
                n_base = base_inc;
                if (base_inc == r_target) begin
                    n_out_vld = 1'b1;
                    n_out     = '0;
                    n_state   = S_IDLE;
                end
            end
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_ptr;
                n_ptr     = r_ptr + ADDR_W'(1);
                if (r_ptr == ADDR_W'(DEPTH - 1)) begin
                    n_state   = S_IDLE;
                    n_out_vld = r_report;
                    n_out     = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_term    <= '0;
            r_base    <= '0;
            r_ptr     <= '0;
            r_report  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_term    <= n_term;
            r_base    <= n_base;
            r_ptr     <= n_ptr;
            r_report  <= n_report;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_req_idx <= n_req_idx;
        r_req_trm <= n_req_trm;
        r_out     <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

[hdl/lerw_checker.sv]
// ----------------------------------------------------------------------------
// lerw_checker
// port-level checks of the reorder window transaction sequencing, bound to
// the top level
// ----------------------------------------------------------------------------
module lerw_checker
    import lerw_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_item,
    input logic      o_valid,
    input t_out_item o_result
);

    // results only follow an accepted transaction or work in progress
    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a pending transaction");

    // the block is ready again in the cycle its result shows
    a_ready_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while a result is shown");

    // add and contains answer in the next cycle
    a_fast_cmds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.cmd == CMD_ADD || i_item.cmd == CMD_CONTAINS))
        |=> (o_valid && !busy))
        else $error("add or contains result late");

    // get next is busy in the check state without a result, then strobes its result
    a_get_next_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.cmd == CMD_GET_NEXT) |=> (busy && !o_valid) ##1 o_valid)
        else $error("get next result timing wrong");

    // entry fields are zero unless an entry was found
    a_zero_when_missed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |->
        (o_result.entry_prev_index == '0 && o_result.entry_prev_term == '0 &&
         o_result.entry_payload == '0))
        else $error("entry fields set on a miss");

endmodule

bind log_entry_reorder_window_top lerw_checker u_lerw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

[tb/sv/log_entry_reorder_window_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// log_entry_reorder_window_top_test
// self-checking bench for the log entry reorder window
// ----------------------------------------------------------------------------
// Commands go in one transaction at a time through start/busy. A monitor
// predicts every accepted command from its own copy of the window state and
// compares each strobed result field by field with the oldest prediction.
// A short directed part covers the window edges, index wrap and term
// changes. Random episodes then set a head, fill the window out of order,
// query it and drain it in order, mixed with mismatching get next requests
// and fully random commands. The sender idles at 12, 62 and 0 percent.
// ----------------------------------------------------------------------------
module log_entry_reorder_window_top_test;
    import lerw_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int SLOT_BITS     = $clog2(DEPTH);
    localparam int MAX_FILL      = 16;
    localparam longint CYCLE_LIMIT = 8_000_000;
    localparam logic [63:0] PAYLOAD_MASK = {64{1'b1}} >> (64 - PAYLOAD_WIDTH);

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_item;
    logic      o_valid;
    t_out_item o_result;

    // predicted window state
    logic [31:0] cur_term;
    logic [31:0] win_base;
    bit          slot_live [DEPTH];
    logic [31:0] slot_idx  [DEPTH];
    logic [31:0] slot_trm  [DEPTH];
    logic [63:0] slot_data [DEPTH];

    t_out_item pending_results [$];

    // stimulus side view of the window
    logic [31:0] g_base;
    logic [31:0] g_term;
    int          g_idle_pct;
    int          g_sent;

    int     n_fail;
    int     n_set, n_add, n_get, n_get_hit, n_contains;
    longint n_cycles;

    log_entry_reorder_window_top #(
        .DEPTH        (DEPTH),
        .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void clear_slots();
        foreach (slot_live[s]) slot_live[s] = 1'b0;
    endfunction

    function automatic bit in_window(input logic [31:0] idx);
        logic [32:0] lo;
        lo = {1'b0, win_base};
        return ({1'b0, idx} >= lo) && ({1'b0, idx} < lo + 33'(DEPTH));
    endfunction

    function automatic t_out_item predict_window(input t_in_item it);
        t_out_item res;
        logic [SLOT_BITS-1:0] pos;
        res = '0;
        case (it.cmd)
            CMD_SET_HEAD: begin
                n_set++;
                if (it.term != cur_term) begin
                    clear_slots();
                    cur_term = it.term;
                end
                if (!in_window(it.index)) begin
                    clear_slots();
                    win_base = it.index;
                end
                while (win_base != it.index) begin
                    slot_live[win_base[SLOT_BITS-1:0]] = 1'b0;
                    win_base = win_base + 32'd1;
                end
            end
            CMD_ADD: begin
                n_add++;
                pos = SLOT_BITS'(it.index + 32'd1);
                slot_idx[pos]  = it.index;
                slot_trm[pos]  = it.term;
                slot_data[pos] = it.new_payload & PAYLOAD_MASK;
                slot_live[pos] = 1'b1;
            end
            CMD_GET_NEXT: begin
                n_get++;
                pos = win_base[SLOT_BITS-1:0];
                if (slot_live[pos] && slot_idx[pos] == it.index
                        && slot_trm[pos] == it.term) begin
                    n_get_hit++;
                    res.found            = 1'b1;
                    res.entry_prev_index = slot_idx[pos];
                    res.entry_prev_term  = slot_trm[pos];
                    res.entry_payload    = slot_data[pos] & PAYLOAD_MASK;
                    slot_live[pos]       = 1'b0;
                    win_base             = win_base + 32'd1;
                end
            end
            default: begin
                n_contains++;
                res.found = in_window(it.index);
            end
        endcase
        return res;
    endfunction

    // predict on acceptance, check on strobe
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (start && !busy) pending_results.push_back(predict_window(i_item));
            if (o_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction pending");
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.found !== want.found) begin
                        $error("found: expected %0h, got %0h", want.found, o_result.found);
                        n_fail++;
                    end
                    if (o_result.entry_prev_index !== want.entry_prev_index) begin
                        $error("entry_prev_index: expected %0h, got %0h",
                               want.entry_prev_index, o_result.entry_prev_index);
                        n_fail++;
                    end
                    if (o_result.entry_prev_term !== want.entry_prev_term) begin
                        $error("entry_prev_term: expected %0h, got %0h",
                               want.entry_prev_term, o_result.entry_prev_term);
                        n_fail++;
                    end
                    if (o_result.entry_payload !== want.entry_payload) begin
                        $error("entry_payload: expected %0h, got %0h",
                               want.entry_payload, o_result.entry_payload);
                        n_fail++;
                    end
                end
            end
        end
    end

    task automatic send_cmd(input t_cmd c, input logic [31:0] idx,
                            input logic [31:0] trm, input logic [63:0] pl);
        t_in_item it;
        it.cmd         = c;
        it.index       = idx;
        it.term        = trm;
        it.new_payload = pl;
        if (g_idle_pct > 0 && $urandom_range(99) < g_idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < g_idle_pct);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (c == CMD_SET_HEAD) begin
            g_base = idx;
            g_term = trm;
        end
        g_sent++;
    endtask

    function automatic logic [63:0] rand_payload();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed_edges();
        send_cmd(CMD_CONTAINS, 32'd0, 32'd0, 64'd0);
        send_cmd(CMD_CONTAINS, 32'(DEPTH - 1), 32'd0, 64'd0);
        send_cmd(CMD_CONTAINS, 32'(DEPTH), 32'd0, 64'd0);
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFF, 32'd0, 64'd0);
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFF, 32'd0, 64'd0);
        // prev index wraps into slot zero
        send_cmd(CMD_ADD, 32'hFFFF_FFFF, 32'd0, {64{1'b1}});
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFF, 32'd0, 64'd0);
        send_cmd(CMD_ADD, 32'd0, 32'd0, 64'd0);
        send_cmd(CMD_SET_HEAD, 32'd3, 32'd0, 64'd0);
        send_cmd(CMD_SET_HEAD, 32'd3, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_SET_HEAD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 64'd0);
        // window end does not wrap
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFE, 32'd0, 64'd0);
        send_cmd(CMD_CONTAINS, 32'd5, 32'd0, 64'd0);
        send_cmd(CMD_CONTAINS, 32'hFFFF_FFFD, 32'd0, 64'd0);
        send_cmd(CMD_ADD, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, {64{1'b1}});
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFD, 32'd0, 64'd0);
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 64'd0);
        // base wraps to zero
        send_cmd(CMD_GET_NEXT, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_CONTAINS, 32'd0, 32'd0, 64'd0);
        send_cmd(CMD_SET_HEAD, 32'd5, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_SET_HEAD, 32'd2, 32'hFFFF_FFFF, 64'd0);
        send_cmd(CMD_ADD, 32'h8000_0000, 32'hFFFF_FFFF, rand_payload());
    endtask

    // set a head, fill the window out of order, drain it in order
    task automatic test_in_order_stream(input int n_items);
        int target;
        int r;
        int fill;
        int used;
        int tmp;
        int pick;
        int order [MAX_FILL];
        logic [31:0] idx;
        logic [31:0] trm;
        target = g_sent + n_items;
        while (g_sent < target) begin
            r   = $urandom_range(99);
            trm = g_term;
            if (r < 8) begin
                trm = $urandom;
                idx = g_base + 32'($urandom_range(0, 3));
            end else if (r < 13) begin
                idx = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
            end else if (r < 18) begin
                idx = $urandom;
            end else if (r < 22) begin
                idx = g_base + 32'($urandom_range(100, DEPTH - 1));
            end else begin
                idx = g_base + 32'($urandom_range(0, 3));
            end
            send_cmd(CMD_SET_HEAD, idx, trm, rand_payload());

            fill = $urandom_range(1, MAX_FILL);
            for (int j = 0; j < MAX_FILL; j++) order[j] = j;
            for (int j = fill - 1; j > 0; j--) begin
                pick        = $urandom_range(0, j);
                tmp         = order[j];
                order[j]    = order[pick];
                order[pick] = tmp;
            end
            for (int j = 0; j < fill; j++) begin
                r = $urandom_range(99);
                if (r < 12) begin
                    send_cmd(CMD_CONTAINS,
                             g_base + 32'($urandom_range(0, DEPTH + 8)) - 32'd4,
                             $urandom, rand_payload());
                end else if (r < 18) begin
                    send_cmd(CMD_ADD,
                             g_base - 32'd1 + 32'($urandom_range(fill, DEPTH - 1)),
                             $urandom, rand_payload());
                end
                send_cmd(CMD_ADD, g_base - 32'd1 + 32'(order[j]), g_term, rand_payload());
            end

            used = ($urandom_range(99) < 10) ? $urandom_range(0, fill - 1) : fill;
            for (int j = 0; j < used; j++) begin
                r   = $urandom_range(99);
                idx = g_base - 32'd1;
                if (r < 6) begin
                    send_cmd(CMD_GET_NEXT, idx, g_term ^ (32'd1 << $urandom_range(31)),
                             rand_payload());
                end else if (r < 12) begin
                    send_cmd(CMD_GET_NEXT, idx ^ (32'd1 << $urandom_range(31)), g_term,
                             rand_payload());
                end
                send_cmd(CMD_GET_NEXT, idx, g_term, rand_payload());
                g_base = g_base + 32'd1;
            end
            if ($urandom_range(99) < 20)
                send_cmd(CMD_GET_NEXT, g_base - 32'd1, g_term, rand_payload());
        end
    endtask

    task automatic test_random_noise(input int n_items);
        t_cmd        c;
        logic [31:0] idx;
        logic [31:0] trm;
        for (int k = 0; k < n_items; k++) begin
            c   = t_cmd'($urandom_range(3));
            idx = ($urandom_range(1) == 1) ? $urandom
                                           : g_base + 32'($urandom_range(0, 40)) - 32'd20;
            trm = ($urandom_range(3) == 0) ? $urandom : g_term;
            send_cmd(c, idx, trm, rand_payload());
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        cur_term   = '0;
        win_base   = '0;
        g_base     = '0;
        g_term     = '0;
        g_idle_pct = 12;
        g_sent     = 0;
        n_fail     = 0;
        n_cycles   = 0;
        clear_slots();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_in_order_stream(540);
        test_random_noise(80);
        g_idle_pct = 62;
        test_in_order_stream(540);
        test_random_noise(80);
        g_idle_pct = 0;
        test_in_order_stream(540);
        test_random_noise(80);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("covered %0d transactions: %0d set head, %0d add, %0d contains",
                 g_sent, n_set, n_add, n_contains);
        $display("get next %0d with %0d hits, sender idle 12/62/0 pct, %0d mismatches",
                 n_get, n_get_hit, n_fail);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
